// ===== src/gnpm_pkg.sv =====
// Shared types and constants for the gapped needle pair matcher.
`timescale 1ns / 1ps
package gnpm_pkg;

    // Default geometry
    localparam int FIRST_LEN_DEF  = 4;
    localparam int SECOND_LEN_DEF = 6;
    localparam int MAX_GAP_DEF    = 64;
    localparam int POS_BITS_DEF   = 32;

    // Register field widths
    localparam int FIRST_W  = 32;
    localparam int SECOND_W = 48;
    localparam int GAP_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OUT_POS_W = 32;
    localparam int COUNT_W   = 32;

    // Gap compares are done at this width so MAX_GAP up to 511 fits
    localparam int GAP_CMP_W = 9;

    // Register reset values ("wolf", "enzyme")
    localparam logic [FIRST_W-1:0]  FIRST_RST   = 32'h776F_6C66;
    localparam logic [SECOND_W-1:0] SECOND_RST  = 48'h656E_7A79_6D65;
    localparam logic [GAP_W-1:0]    GAP_MIN_RST = 7'd0;
    localparam logic [GAP_W-1:0]    GAP_MAX_RST = 7'd64;
    localparam logic                REQ_RST     = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_NEEDLE  = 3'd0,
        CFG_SECOND_NEEDLE = 3'd1,
        CFG_GAP_MIN       = 3'd2,
        CFG_GAP_MAX       = 3'd3,
        CFG_REQUIRE_FIRST = 3'd4
    } t_cfg_idx;

    // Configuration bundle
    typedef struct packed {
        logic [FIRST_W-1:0]  first_needle;
        logic [SECOND_W-1:0] second_needle;
        logic [GAP_W-1:0]    gap_min;
        logic [GAP_W-1:0]    gap_max;
        logic                require_first;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic                 match_found;
        logic [OUT_POS_W-1:0] match_start;
        logic [COUNT_W-1:0]   match_total;
        logic                 text_done;
    } t_result;

endpackage

// ===== src/gnpm_cfg_regs.sv =====
// Configuration register file: needles, gap window and mode bit.
`timescale 1ns / 1ps
module gnpm_cfg_regs
    import gnpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_needle  <= FIRST_RST;
            r_cfg.second_needle <= SECOND_RST;
            r_cfg.gap_min       <= GAP_MIN_RST;
            r_cfg.gap_max       <= GAP_MAX_RST;
            r_cfg.require_first <= REQ_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FIRST_NEEDLE:  r_cfg.first_needle  <= i_cfg_data[FIRST_W-1:0];
                CFG_SECOND_NEEDLE: r_cfg.second_needle <= i_cfg_data[SECOND_W-1:0];
                CFG_GAP_MIN:       r_cfg.gap_min       <= i_cfg_data[GAP_W-1:0];
                CFG_GAP_MAX:       r_cfg.gap_max       <= i_cfg_data[GAP_W-1:0];
                CFG_REQUIRE_FIRST: r_cfg.require_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/gnpm_match_core.sv =====
// Match core: byte history, position, first-needle start line and counter.
`timescale 1ns / 1ps
module gnpm_match_core
    import gnpm_pkg::*;
#(
    parameter int FIRST_LEN  = FIRST_LEN_DEF,
    parameter int SECOND_LEN = SECOND_LEN_DEF,
    parameter int MAX_GAP    = MAX_GAP_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    output t_result    o_result
);

    localparam int KEEP   = (FIRST_LEN > SECOND_LEN) ? FIRST_LEN : SECOND_LEN;
    localparam int HIST_W = 8 * KEEP;
    localparam int WIN_W  = HIST_W + 8;
    localparam int FILL_W = $clog2(KEEP + 1);
    // Slot j holds a first-needle start FIRST_LEN+j bytes before the next byte
    localparam int SLOTS  = SECOND_LEN + MAX_GAP;

    logic [HIST_W-1:0]   r_hist,   n_hist;
    logic [POS_BITS-1:0] r_pos,    n_pos;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [SLOTS-1:0]    r_starts, n_starts;
    logic [COUNT_W-1:0]  r_count,  n_count;

    logic [WIN_W-1:0]    window;
    logic [63:0]         needle1;
    logic [63:0]         needle2;
    logic                first_hit;
    logic                second_hit;
    logic                pair_hit;
    logic                found;
    logic [POS_BITS-1:0] start_pos;

    // Window, fill count and needle compares
    always_comb begin
        window  = {r_hist, i_data_byte};
        needle1 = 64'(i_cfg.first_needle);
        needle2 = 64'(i_cfg.second_needle);
        n_fill  = (r_fill == FILL_W'(KEEP)) ? r_fill : r_fill + FILL_W'(1);
        first_hit  = (n_fill >= FILL_W'(FIRST_LEN)) &&
                     (window[8*FIRST_LEN-1:0] == needle1[8*FIRST_LEN-1:0]);
        second_hit = (n_fill >= FILL_W'(SECOND_LEN)) &&
                     (window[8*SECOND_LEN-1:0] == needle2[8*SECOND_LEN-1:0]);
    end

    // Age the start line by one byte and look for a start inside the gap window
    always_comb begin
        n_starts[0] = first_hit;
        for (int j = 1; j < SLOTS; j++) begin
            n_starts[j] = r_starts[j-1];
        end
        pair_hit = 1'b0;
        for (int g = 0; g <= MAX_GAP; g++) begin
            if (r_starts[SECOND_LEN-1+g] &&
                (GAP_CMP_W'(g) >= GAP_CMP_W'(i_cfg.gap_min)) &&
                (GAP_CMP_W'(g) <= GAP_CMP_W'(i_cfg.gap_max))) begin
                pair_hit = 1'b1;
            end
        end
    end

    // Result and next state
    always_comb begin
        found     = second_hit && (!i_cfg.require_first || pair_hit);
        start_pos = r_pos - POS_BITS'(SECOND_LEN - 1);
        n_count   = r_count;
        if (found && (r_count != '1)) begin
            n_count = r_count + COUNT_W'(1);
        end
        n_hist = window[HIST_W-1:0];
        n_pos  = r_pos + POS_BITS'(1);

        o_result.match_found = found;
        o_result.match_start = found ? OUT_POS_W'(start_pos) : '0;
        o_result.match_total = n_count;
        o_result.text_done   = i_end_of_text;
    end

    // State update per byte; end of text starts a fresh haystack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_pos    <= '0;
            r_fill   <= '0;
            r_starts <= '0;
            r_count  <= '0;
        end else if (i_advance) begin
            if (i_end_of_text) begin
                r_hist   <= '0;
                r_pos    <= '0;
                r_fill   <= '0;
                r_starts <= '0;
                r_count  <= '0;
            end else begin
                r_hist   <= n_hist;
                r_pos    <= n_pos;
                r_fill   <= n_fill;
                r_starts <= n_starts;
                r_count  <= n_count;
            end
        end
    end

endmodule

// ===== src/gapped_needle_pair_matcher_unit.sv =====
// Top level of the gapped needle pair matcher: input and result registers.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one haystack byte per
//   transfer plus an end-of-text flag that closes the current haystack.
//   Output channel (o_out_valid / i_out_ready) carries one result per byte:
//   match flag, start position of the second needle, running saturating
//   count for this haystack and the echoed end-of-text flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes needles, gap window
//   and mode by index; it is always ready and should be used while idle.
//   Each byte passes through one input register and then one result
//   register before its result shows on the output.
//   Throughput: one byte per clock while the receiver does not stall, set
//   by the single compare-and-update step of the match core between them.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; ready then drops until the
//   result is taken.
//   Reset (synchronous, active low) restores the register defaults, clears
//   byte history, position, start line and counter, and empties the pipe.
module gapped_needle_pair_matcher_unit
    import gnpm_pkg::*;
#(
    parameter int FIRST_LEN  = FIRST_LEN_DEF,
    parameter int SECOND_LEN = SECOND_LEN_DEF,
    parameter int MAX_GAP    = MAX_GAP_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_match_found,
    output logic [OUT_POS_W-1:0]  o_match_start,
    output logic [COUNT_W-1:0]    o_match_total,
    output logic                  o_text_done
);

    t_cfg       cfg;
    t_result    core_result;
    logic       out_load;
    logic       advance;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;
    logic       r_out_valid;
    t_result    r_out;

    gnpm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gnpm_match_core #(
        .FIRST_LEN  (FIRST_LEN),
        .SECOND_LEN (SECOND_LEN),
        .MAX_GAP    (MAX_GAP),
        .POS_BITS   (POS_BITS)
    ) u_match_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_advance     (advance),
        .i_data_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .o_result      (core_result)
    );

    // Pipe control: result register frees up when empty or being taken
    assign out_load   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_found = r_out.match_found;
    assign o_match_start = r_out.match_start;
    assign o_match_total = r_out.match_total;
    assign o_text_done   = r_out.text_done;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the gapped needle pair matcher unit.
`timescale 1ns / 1ps
module tb;
    import gnpm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 40;
    localparam int PHASE_BYTES = 50;
    localparam int STALL_LEN   = 48;
    localparam int START_LINE  = SECOND_LEN_DEF + FIRST_LEN_DEF + MAX_GAP_DEF + 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    // Tracks needles, gap window and per-text state; holds expected results
    class match_scoreboard;
        logic [FIRST_W-1:0]    first_ndl;
        logic [SECOND_W-1:0]   second_ndl;
        logic [GAP_W-1:0]      gap_lo;
        logic [GAP_W-1:0]      gap_hi;
        logic                  pair_mode;
        logic [55:0]           history;
        logic [OUT_POS_W-1:0]  position;
        logic [START_LINE-1:0] first_starts;
        logic [COUNT_W-1:0]    total;
        int unsigned           seen;
        t_result               expected_q[$];
        int unsigned           errors, results, hits, texts, bytes;

        function new();
            first_ndl  = FIRST_RST;
            second_ndl = SECOND_RST;
            gap_lo     = GAP_MIN_RST;
            gap_hi     = GAP_MAX_RST;
            pair_mode  = REQ_RST;
            errors     = 0;
            results    = 0;
            hits       = 0;
            texts      = 0;
            bytes      = 0;
            clear_text();
        endfunction

        function void clear_text();
            history      = '0;
            position     = '0;
            first_starts = '0;
            total        = '0;
            seen         = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIRST_NEEDLE:  first_ndl  = data[FIRST_W-1:0];
                CFG_SECOND_NEEDLE: second_ndl = data[SECOND_W-1:0];
                CFG_GAP_MIN:       gap_lo     = data[GAP_W-1:0];
                CFG_GAP_MAX:       gap_hi     = data[GAP_W-1:0];
                CFG_REQUIRE_FIRST: pair_mode  = data[0];
                default: ;
            endcase
        endfunction

        // Work out the result of one transferred byte
        function void note_byte(logic [7:0] b, logic eot);
            logic [63:0] window;
            t_result     want;
            int          top;
            int          g;
            window = {history, b};
            if (seen < 8) seen++;
            first_starts = first_starts << 1;
            if (seen >= FIRST_LEN_DEF && window[FIRST_W-1:0] == first_ndl)
                first_starts[FIRST_LEN_DEF-1] = 1'b1;
            want = '0;
            if (seen >= SECOND_LEN_DEF && window[SECOND_W-1:0] == second_ndl) begin
                if (!pair_mode) begin
                    want.match_found = 1'b1;
                end else begin
                    // gap_max above the hardware limit is clamped
                    top = (gap_hi > MAX_GAP_DEF) ? MAX_GAP_DEF : gap_hi;
                    for (g = gap_lo; g <= top; g++)
                        if (first_starts[SECOND_LEN_DEF - 1 + FIRST_LEN_DEF + g])
                            want.match_found = 1'b1;
                end
            end
            if (want.match_found) begin
                want.match_start = position - (SECOND_LEN_DEF - 1);
                if (total != '1) total++;
            end
            want.match_total = total;
            want.text_done   = eot;
            expected_q.push_back(want);
            history = window[55:0];
            position++;
            bytes++;
            if (eot) begin
                texts++;
                clear_text();
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("tb: mismatch on result %0d: %s", results, what);
        endtask

        // Compare one transferred result against the oldest expectation
        task check_result(logic found, logic [OUT_POS_W-1:0] start,
                          logic [COUNT_W-1:0] count, logic done);
            t_result want;
            results++;
            if (expected_q.size() == 0) begin
                report("result arrived with no byte outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (want.match_found) hits++;
            if (found !== want.match_found)
                report($sformatf("match_found %0b, expected %0b", found, want.match_found));
            if (start !== want.match_start)
                report($sformatf("match_start %0d, expected %0d", start, want.match_start));
            if (count !== want.match_total)
                report($sformatf("match_total %0d, expected %0d", count, want.match_total));
            if (done !== want.text_done)
                report($sformatf("text_done %0b, expected %0b", done, want.text_done));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte;
    logic                  i_end_of_text;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_match_found;
    logic [OUT_POS_W-1:0]  o_match_start;
    logic [COUNT_W-1:0]    o_match_total;
    logic                  o_text_done;

    logic [FIRST_W-1:0]    cur_first;
    logic [SECOND_W-1:0]   cur_second;
    logic [GAP_W-1:0]      cur_lo;
    logic [GAP_W-1:0]      cur_hi;
    logic [7:0]            text_q[$];
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    stall_request;
    int                    hold_left;
    int                    quiet;
    int                    sent;
    match_scoreboard       board;

    gapped_needle_pair_matcher_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_found (o_match_found),
        .o_match_start (o_match_start),
        .o_match_total (o_match_total),
        .o_text_done   (o_text_done)
    );

    always #2 i_clk = ~i_clk;

    // Result side: check each transfer, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_match_found, o_match_start, o_match_total, o_text_done);
        // long hold only starts once something is waiting, so the pipe backs up
        if (stall_request != 0 && o_out_valid) begin
            hold_left     = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Noise leans on needle bytes so near misses are common
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return cur_first[8*$urandom_range(3) +: 8];
            1:       return cur_second[8*$urandom_range(5) +: 8];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_noise(int n);
        int i;
        for (i = 0; i < n; i++) text_q.push_back(noise_byte());
    endfunction

    function automatic void push_first(int n);
        int i;
        for (i = 0; i < n; i++) text_q.push_back(cur_first[FIRST_W-1-8*i -: 8]);
    endfunction

    function automatic void push_second(int n);
        int i;
        for (i = 0; i < n; i++) text_q.push_back(cur_second[SECOND_W-1-8*i -: 8]);
    endfunction

    // Gap lengths cluster on the window edges
    function automatic int pick_gap();
        int top;
        top = (cur_hi > MAX_GAP_DEF) ? MAX_GAP_DEF : cur_hi;
        if (cur_lo > top) return $urandom_range(top + 4);
        case ($urandom_range(3))
            0:       return $urandom_range(70);
            1:       return $urandom_range(top, cur_lo);
            2:       return (cur_lo == 0) ? $urandom_range(1) : cur_lo - 1 + $urandom_range(2);
            default: return (top == 0) ? $urandom_range(1) : top - 1 + $urandom_range(2);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Full register set; junk above each field narrower than the data word must be dropped
    task automatic setup(logic [FIRST_W-1:0] first, logic [SECOND_W-1:0] second,
                         logic [GAP_W-1:0] lo, logic [GAP_W-1:0] hi, logic req);
        logic [47:0] junk;
        junk       = rand48();
        cur_first  = first;
        cur_second = second;
        cur_lo     = lo;
        cur_hi     = hi;
        write_reg(CFG_FIRST_NEEDLE, {junk[47:32], first});
        write_reg(CFG_SECOND_NEEDLE, second);
        write_reg(CFG_GAP_MIN, {junk[47:7], lo});
        write_reg(CFG_GAP_MAX, {junk[40:0], hi});
        write_reg(CFG_REQUIRE_FIRST, {junk[46:0], req});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b, logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_byte(b, eot);
        sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Stop offering and let every outstanding result come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_text();
        int kind;
        text_q.delete();
        push_noise($urandom_range(3));
        kind = $urandom_range(9);
        if (kind <= 6) begin
            // well-formed pairs, sometimes two per text
            repeat (1 + ($urandom_range(3) == 0)) begin
                push_first(FIRST_LEN_DEF);
                push_noise(pick_gap());
                push_second(SECOND_LEN_DEF);
                if (kind == 6)
                    repeat ($urandom_range(1, 3)) text_q.push_back(cur_second[7:0]);
            end
        end else if (kind == 7) begin
            // one needle cut short
            if ($urandom_range(1)) begin
                push_first($urandom_range(1, FIRST_LEN_DEF - 1));
                push_noise(pick_gap());
                push_second(SECOND_LEN_DEF);
            end else begin
                push_first(FIRST_LEN_DEF);
                push_noise(pick_gap());
                push_second($urandom_range(1, SECOND_LEN_DEF - 1));
            end
        end else if (kind == 8) begin
            // noise ending on a first needle that the next text must not use
            push_noise($urandom_range(1, 10));
            if ($urandom_range(1)) push_first(FIRST_LEN_DEF);
        end else begin
            push_second(SECOND_LEN_DEF);
        end
        push_noise($urandom_range(2));
        send_text();
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        int start;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start          = sent;
        while (sent - start < PHASE_BYTES) send_random_text();
        drain();
    endtask

    initial begin
        logic [GAP_W-1:0] lo;
        logic [7:0]       rep;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_data_byte    = '0;
        i_end_of_text  = 1'b0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_request  = 0;
        hold_left      = 0;
        quiet          = 0;
        sent           = 0;
        board          = new();
        cur_first      = FIRST_RST;
        cur_second     = SECOND_RST;
        cur_lo         = GAP_MIN_RST;
        cur_hi         = GAP_MAX_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset needles: adjacent pair in one text
        push_first(FIRST_LEN_DEF);
        push_second(SECOND_LEN_DEF);
        send_text();
        // pair split across two texts must not match
        text_q.delete();
        push_first(FIRST_LEN_DEF);
        send_text();
        text_q.delete();
        push_second(SECOND_LEN_DEF);
        send_text();
        // second needle split across texts
        text_q.delete();
        push_second(4);
        send_text();
        text_q.delete();
        text_q.push_back(cur_second[15:8]);
        text_q.push_back(cur_second[7:0]);
        send_text();
        // extreme byte values, then a one-byte text
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b1);
        drain();

        // narrow random window, free-running both sides
        lo = GAP_W'($urandom_range(4));
        setup($urandom, rand48(), lo, GAP_W'(lo + $urandom_range(10)), 1'b1);
        run_phase(0, 0);
        // adjacent needles only, sender gaps
        setup($urandom, rand48(), 0, 0, 1'b1);
        run_phase(67, 0);
        // far end of the window, upper bound past the clamp, receiver stalls
        setup($urandom, rand48(), 60, 127, 1'b1);
        run_phase(0, 67);
        // empty window; a spare register index must be ignored
        write_reg(CFG_SPARE_IDX, rand48());
        setup($urandom, rand48(), 127, 0, 1'b1);
        run_phase(16, 16);
        // find-all with a repetitive needle (overlaps), long output hold
        rep = 8'($urandom_range(255));
        stall_request = STALL_LEN;
        setup($urandom, {6{rep}}, 0, 64, 1'b0);
        run_phase(0, 0);
        // all-zero and all-one needles against cleared history
        lo = GAP_W'($urandom_range(8));
        setup('0, '1, lo, GAP_W'(lo + $urandom_range(20)), 1'b1);
        run_phase(0, 67);
        // everything random
        setup($urandom, rand48(), GAP_W'($urandom_range(20)), GAP_W'($urandom_range(70)),
              1'($urandom_range(1)));
        run_phase(67, 0);

        $display("tb: covered %0d bytes in %0d texts, %0d matches reported",
                 board.bytes, board.texts, board.hits);
        $display("tb: gap windows zero, narrow, clamped and empty; pair and find-all modes");
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gnpm_pkg.sv
src/gnpm_cfg_regs.sv
src/gnpm_match_core.sv
src/gapped_needle_pair_matcher_unit.sv
dv/tb.sv
